// ===== src/fdl_pkg.sv =====
// Shared constants and types for the fractional delay line.
package fdl_pkg;

  // Default sizing of the sample store and sample words.
  localparam int DEPTH_DEF       = 4096;
  localparam int SAMPLE_BITS_DEF = 24;

  // Configuration register widths and reset values.
  localparam int DWHOLE_BITS = 12;
  localparam int DFRAC_BITS  = 16;
  localparam int GAIN_BITS   = 16;
  localparam int LEN_BITS    = 13;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 4;

  localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd4096;
  localparam logic [LEN_BITS-1:0]  LEN_RESET  = 13'd4096;

  // Fixed-point positions: fraction is Q0.16, gain is Q4.12.
  localparam int FRAC_BITS  = 16;
  localparam int GAIN_SHIFT = 12;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_DELAY_WHOLE   = 4'd0,
    CFG_DELAY_FRAC    = 4'd1,
    CFG_OUT_GAIN      = 4'd2,
    CFG_LENGTH_IN_USE = 4'd3
  } cfg_idx_t;

endpackage

// ===== src/fractional_delay_line.sv =====
// Fractional delay line: top level with sequencer, shared multiplier and config registers.
// A new input word is taken only after the last result is loaded into the output register;
// the sequencer walks whole-delay clamping, address setup, two store reads, the tap
// difference and two passes through one shared multiplier.
// Reset clears the store by a fill mark (no clearing pass), loads register defaults
// and empties the output register.
module fractional_delay_line import fdl_pkg::*; #(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data
);

  localparam int SB = SAMPLE_BITS;
  localparam int AW = $clog2(DEPTH);
  localparam int LW = AW + 1;
  localparam int PW = SB + FRAC_BITS + 2;

  localparam logic signed [PW-1:0] HALF_FRAC = PW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [PW-1:0] HALF_GAIN = PW'(1) <<< (GAIN_SHIFT - 1);
  localparam logic signed [PW-1:0] SAT_HI    = (PW'(1) <<< (SB - 1)) - PW'(1);
  localparam logic signed [PW-1:0] SAT_LO    = -SAT_HI - PW'(1);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_DLY  = 10'b0000000010,
    S_RADR = 10'b0000000100,
    S_RD0  = 10'b0000001000,
    S_RD1  = 10'b0000010000,
    S_DIFF = 10'b0000100000,
    S_MULF = 10'b0001000000,
    S_INTP = 10'b0010000000,
    S_MULG = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [DWHOLE_BITS-1:0] cfg_dwhole_r;
  logic [DFRAC_BITS-1:0]  cfg_dfrac_r;
  logic [GAIN_BITS-1:0]   cfg_gain_r;
  logic [LEN_BITS-1:0]    cfg_len_r;

  // Control and datapath registers.
  logic [AW-1:0]          write_pos_r, write_pos_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic signed [SB-1:0]   out_sample_r;
  logic signed [SB-1:0]   x_r;
  logic [LW-1:0]          len_r;
  logic [AW-1:0]          wp_r;
  logic                   bypass_r;
  logic [AW-1:0]          d_r;
  logic                   dz_r;
  logic [AW-1:0]          r_r;
  logic [AW-1:0]          r1_r;
  logic signed [SB-1:0]   y_r;
  logic signed [SB:0]     diff_r;
  logic signed [PW-1:0]   mul_p_r;
  logic signed [SB-1:0]   interp_r;

  // Combinational signals.
  logic                   in_acc;
  logic                   out_load;
  logic [31:0]            len_wide;
  logic [LW-1:0]          len_c;
  logic [AW-1:0]          wp_c;
  logic [LW-1:0]          len_m1;
  logic [AW-1:0]          d_c;
  logic [LW:0]            sum_c;
  logic [LW:0]            sum_red;
  logic [AW-1:0]          r_c;
  logic [AW-1:0]          r1_c;
  logic [LW-1:0]          wp_inc;
  logic signed [SB:0]     mul_a;
  logic signed [GAIN_BITS:0] mul_b;
  logic signed [PW-1:0]   mul_full;
  logic signed [PW-1:0]   acc_c;
  logic signed [PW-1:0]   g_c;
  logic signed [PW-1:0]   gr_c;
  logic signed [SB-1:0]   sat_c;
  logic [AW-1:0]          rd_addr;
  logic signed [SB-1:0]   rd_data;
  logic                   st_we;

  // Registers change only between words; a pending register write goes before
  // the next input word.
  assign in_ready  = (state_r == S_IDLE) && !cfg_valid;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  // Configuration register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_dwhole_r <= '0;
      cfg_dfrac_r  <= '0;
      cfg_gain_r   <= GAIN_RESET;
      cfg_len_r    <= LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DELAY_WHOLE:   cfg_dwhole_r <= cfg_data[DWHOLE_BITS-1:0];
        CFG_DELAY_FRAC:    cfg_dfrac_r  <= cfg_data[DFRAC_BITS-1:0];
        CFG_OUT_GAIN:      cfg_gain_r   <= cfg_data[GAIN_BITS-1:0];
        CFG_LENGTH_IN_USE: cfg_len_r    <= cfg_data[LEN_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Length in use, clamped to one through DEPTH, and the effective write position.
  assign len_wide = 32'(cfg_len_r);
  always_comb begin
    if (cfg_len_r == '0) begin
      len_c = LW'(1);
    end else if (len_wide > 32'(DEPTH)) begin
      len_c = LW'(DEPTH);
    end else begin
      len_c = LW'(cfg_len_r);
    end
  end
  assign wp_c = ({1'b0, write_pos_r} < len_c) ? write_pos_r : '0;

  // Whole delay clamped to length minus one.
  assign len_m1 = len_r - LW'(1);
  assign d_c = (32'(cfg_dwhole_r) > 32'(len_m1)) ? len_m1[AW-1:0] : AW'(cfg_dwhole_r);

  // Read position of the newer tap, modulo the length.
  assign sum_c   = (LW+1)'(wp_r) + (LW+1)'(len_r) - (LW+1)'(d_r);
  assign sum_red = sum_c - (LW+1)'(len_r);
  assign r_c     = (sum_c >= (LW+1)'(len_r)) ? sum_red[AW-1:0] : sum_c[AW-1:0];

  // Older tap sits one place back, wrapping to the end of the used length.
  assign r1_c = (r_r == '0) ? len_m1[AW-1:0] : (r_r - AW'(1));

  // Next write position after storing the input.
  assign wp_inc = {1'b0, wp_r} + LW'(1);
  always_comb begin
    write_pos_nxt = write_pos_r;
    if (state_r == S_DIFF) begin
      write_pos_nxt = (wp_inc >= len_r) ? '0 : wp_inc[AW-1:0];
    end
  end

  // Store access: newer tap, then older tap, then the write of the input.
  assign rd_addr = (state_r == S_RD0) ? r_r : r1_r;
  assign st_we   = (state_r == S_DIFF);

  fdl_store #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (st_we),
    .wr_addr (wp_r),
    .wr_data (x_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Shared multiplier: tap difference times fraction, then sample times gain.
  always_comb begin
    if (state_r == S_MULG) begin
      mul_a = {interp_r[SB-1], interp_r};
      mul_b = {1'b0, cfg_gain_r};
    end else begin
      mul_a = diff_r;
      mul_b = {1'b0, cfg_dfrac_r};
    end
  end
  assign mul_full = PW'(mul_a) * PW'(mul_b);

  // Interpolation sum, rounded to nearest with ties upward.
  assign acc_c = ($signed({{(PW-SB){y_r[SB-1]}}, y_r}) <<< FRAC_BITS) + mul_p_r + HALF_FRAC;

  // Gain rounding and saturation to the sample width.
  assign g_c  = mul_p_r + HALF_GAIN;
  assign gr_c = g_c >>> GAIN_SHIFT;
  always_comb begin
    if (gr_c > SAT_HI) begin
      sat_c = SAT_HI[SB-1:0];
    end else if (gr_c < SAT_LO) begin
      sat_c = SAT_LO[SB-1:0];
    end else begin
      sat_c = gr_c[SB-1:0];
    end
  end

  // Output register is loaded once the result is ready and the slot is free.
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_DLY;
        end
      end
      S_DLY:  state_nxt = S_RADR;
      S_RADR: state_nxt = S_RD0;
      S_RD0:  state_nxt = S_RD1;
      S_RD1:  state_nxt = S_DIFF;
      S_DIFF: state_nxt = S_MULF;
      S_MULF: state_nxt = S_INTP;
      S_INTP: state_nxt = S_MULG;
      S_MULG: state_nxt = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      write_pos_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      write_pos_r <= write_pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers, each loaded in the step that computes it; mul_p_r in both multiply steps.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r      <= in_sample_in;
      len_r    <= len_c;
      wp_r     <= wp_c;
      bypass_r <= (cfg_dwhole_r == '0) && (cfg_dfrac_r == '0);
    end
    if (state_r == S_DLY) begin
      d_r  <= d_c;
      dz_r <= (d_c == '0);
    end
    if (state_r == S_RADR) begin
      r_r <= r_c;
    end
    if (state_r == S_RD0) begin
      r1_r <= r1_c;
    end
    if (state_r == S_RD1) begin
      y_r <= dz_r ? x_r : rd_data;
    end
    if (state_r == S_DIFF) begin
      diff_r <= {rd_data[SB-1], rd_data} - {y_r[SB-1], y_r};
    end
    if ((state_r == S_MULF) || (state_r == S_MULG)) begin
      mul_p_r <= mul_full;
    end
    if (state_r == S_INTP) begin
      interp_r <= bypass_r ? x_r : acc_c[SB+FRAC_BITS-1:FRAC_BITS];
    end
    if (out_load) begin
      out_sample_r <= sat_c;
    end
  end

  // The clamped whole delay never reaches the used length.
  a_delay_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RADR) |-> ({1'b0, d_r} < len_r))
    else $error("whole delay not below used length");

  // Read positions stay inside the used length.
  a_taps_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD1) |-> (({1'b0, r_r} < len_r) && ({1'b0, r1_r} < len_r)))
    else $error("tap position outside used length");

  // After the input is stored, the write position wraps inside the used length.
  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_we |=> ({1'b0, write_pos_r} < len_r))
    else $error("write position outside used length");

  // A finished word reaches the output register when the slot is free.
  a_result_issued: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("result not issued");

  // No new word is taken while one is in progress.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("input taken while busy");

endmodule

// ===== src/fdl_store.sv =====
// Circular sample store with registered read and a fill mark for reset clearing.
module fdl_store import fdl_pkg::*; #(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [$clog2(DEPTH)-1:0]      wr_addr,
  input  logic signed [SAMPLE_BITS-1:0] wr_data,
  input  logic [$clog2(DEPTH)-1:0]      rd_addr,
  output logic signed [SAMPLE_BITS-1:0] rd_data
);

  localparam int AW = $clog2(DEPTH);

  logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_word_r;
  logic                          rd_ok_r;
  logic [AW:0]                   fill_r;
  logic [AW:0]                   fill_nxt;
  logic [AW:0]                   wr_next;

  // Writes always advance from zero one entry at a time, so the written
  // entries form a prefix of the store; fill_r marks its end.
  assign wr_next = {1'b0, wr_addr} + (AW+1)'(1);

  always_comb begin
    fill_nxt = fill_r;
    if (wr_en && ({1'b0, wr_addr} >= fill_r)) begin
      fill_nxt = wr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_word_r <= mem[rd_addr];
    rd_ok_r   <= ({1'b0, rd_addr} < fill_r);
  end

  // Entries not yet written since reset read as zero.
  assign rd_data = rd_ok_r ? rd_word_r : '0;

endmodule
